[sv/subspace_projection_pkg.sv]
`default_nettype none
package subproj_pkg;

    localparam int IDX_W   = 5;
    localparam int ROW_W   = 4;
    localparam int ELEM_W  = 16;
    localparam int COEF_W  = 24;
    localparam int PROD_W  = COEF_W + ELEM_W;
    localparam int ACC_W   = 48;
    localparam int FRAC_W  = 15;
    localparam int DIM_W   = 6;
    localparam int CNT_W   = 4;
    localparam int DRAIN_W = 2;
    localparam logic [DRAIN_W-1:0] DRAIN_LAST = 2'd2;

    localparam logic OP_BASIS   = 1'b0;
    localparam logic OP_VECTOR  = 1'b1;
    localparam logic KIND_COEF  = 1'b0;
    localparam logic KIND_PROJ  = 1'b1;
    localparam logic REG_DIM    = 1'b0;
    localparam logic REG_COUNT  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PASS1,
        ST_DRAIN1,
        ST_PASS2,
        ST_DRAIN2
    } state_t;

    // one multiply-accumulate step, travels down the datapath pipeline
    typedef struct packed {
        logic             valid;
        logic             kind;
        logic             first;
        logic             last;
        logic             final_out;
        logic [IDX_W-1:0] idx;
    } mac_cmd_t;

    // floor((x + 2^14) / 2^15), clamped to signed 24 bits
    function automatic logic signed [COEF_W-1:0] round_sat(input logic signed [ACC_W-1:0] x);
        logic signed [ACC_W:0]        y;
        logic [ACC_W-FRAC_W:0]        q;
        logic signed [COEF_W-1:0]     r;
        y = $signed({x[ACC_W-1], x}) + $signed((ACC_W+1)'(1 << (FRAC_W - 1)));
        q = y[ACC_W:FRAC_W];
        if ((&q[ACC_W-FRAC_W:COEF_W-1]) || !(|q[ACC_W-FRAC_W:COEF_W-1]))
        begin
            r = $signed(q[COEF_W-1:0]);
        end
        else if (q[ACC_W-FRAC_W])
        begin
            r = $signed({1'b1, {(COEF_W-1){1'b0}}});
        end
        else
        begin
            r = $signed({1'b0, {(COEF_W-1){1'b1}}});
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[sv/subproj_ctrl.sv]
`default_nettype none
module subproj_ctrl
    import subproj_pkg::*;
#(
    parameter int DIM       = 32,
    parameter int NUM_BASIS = 8,
    parameter int BA_W      = 8
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             run_start,
    input  wire logic [IDX_W-1:0] dlast,
    input  wire logic [ROW_W-1:0] rlast,
    output logic                  busy,
    output mac_cmd_t              cmd,
    output logic [BA_W-1:0]       baddr,
    output logic [IDX_W-1:0]      elem,
    output logic [ROW_W-1:0]      row
);

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   i_reg, i_next;
    logic [ROW_W-1:0]   r_reg, r_next;
    logic [DRAIN_W-1:0] drain_reg, drain_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            r_reg     <= '0;
            drain_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            r_reg     <= r_next;
            drain_reg <= drain_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        i_next        = i_reg;
        r_next        = r_reg;
        drain_next    = drain_reg;
        cmd           = '0;
        cmd.idx       = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                i_next = '0;
                r_next = '0;
                if (run_start)
                begin
                    state_next = ST_PASS1;
                end
            end
            ST_PASS1:
            begin
                // row outer, element inner: one coefficient per row
                cmd.valid = 1'b1;
                cmd.kind  = KIND_COEF;
                cmd.first = (i_reg == '0);
                cmd.last  = (i_reg == dlast);
                cmd.idx   = IDX_W'(r_reg);
                if (i_reg == dlast)
                begin
                    i_next = '0;
                    if (r_reg == rlast)
                    begin
                        r_next     = '0;
                        drain_next = '0;
                        state_next = ST_DRAIN1;
                    end
                    else
                    begin
                        r_next = r_reg + 1'b1;
                    end
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                end
            end
            ST_DRAIN1:
            begin
                // last coefficient lands in the store before pass 2 reads it
                drain_next = drain_reg + 1'b1;
                if (drain_reg == DRAIN_LAST)
                begin
                    state_next = ST_PASS2;
                end
            end
            ST_PASS2:
            begin
                // element outer, row inner: one component per element
                cmd.valid     = 1'b1;
                cmd.kind      = KIND_PROJ;
                cmd.first     = (r_reg == '0);
                cmd.last      = (r_reg == rlast);
                cmd.final_out = (r_reg == rlast) && (i_reg == dlast);
                cmd.idx       = i_reg;
                if (r_reg == rlast)
                begin
                    r_next = '0;
                    if (i_reg == dlast)
                    begin
                        i_next     = '0;
                        drain_next = '0;
                        state_next = ST_DRAIN2;
                    end
                    else
                    begin
                        i_next = i_reg + 1'b1;
                    end
                end
                else
                begin
                    r_next = r_reg + 1'b1;
                end
            end
            ST_DRAIN2:
            begin
                drain_next = drain_reg + 1'b1;
                if (drain_reg == DRAIN_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy  = (state_reg != ST_IDLE);
    assign elem  = i_reg;
    assign row   = r_reg;
    assign baddr = BA_W'(int'(r_reg) * DIM + int'(i_reg));

    a_cmd_only_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.valid |-> (state_reg == ST_PASS1 || state_reg == ST_PASS2))
        else $error("step issued outside a pass");

    a_final_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.final_out |-> (cmd.last && cmd.kind == KIND_PROJ))
        else $error("final mark without closing step");

    a_pass1_to_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PASS1 && cmd.last && r_reg == rlast) |=> (state_reg == ST_DRAIN1))
        else $error("pass 1 did not end in drain");

    a_idle_after_final: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.final_out |-> ##3 (state_reg == ST_DRAIN2 && drain_reg == DRAIN_LAST))
        else $error("drain length wrong after final step");

endmodule
`default_nettype wire

[sv/subproj_datapath.sv]
`default_nettype none
module subproj_datapath
    import subproj_pkg::*;
#(
    parameter int DIM       = 32,
    parameter int NUM_BASIS = 8,
    parameter int BA_W      = 8,
    parameter int VA_W      = 5,
    parameter int CA_W      = 3
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     bwe,
    input  wire logic [BA_W-1:0]          bwaddr,
    input  wire logic                     vwe,
    input  wire logic [VA_W-1:0]          vwaddr,
    input  wire logic signed [ELEM_W-1:0] wdata,
    input  wire mac_cmd_t                 cmd,
    input  wire logic [BA_W-1:0]          baddr,
    input  wire logic [IDX_W-1:0]         elem,
    input  wire logic [ROW_W-1:0]         row,
    output logic                          result_strobe,
    output logic                          result_kind,
    output logic [IDX_W-1:0]              result_index,
    output logic signed [COEF_W-1:0]      result_value,
    output logic                          last_result
);

    logic signed [ELEM_W-1:0] basis_mem [NUM_BASIS*DIM];
    logic signed [ELEM_W-1:0] vec_mem   [DIM];
    logic signed [COEF_W-1:0] coef_mem  [NUM_BASIS];

    logic signed [ELEM_W-1:0] b_rd_reg;
    logic signed [ELEM_W-1:0] v_rd_reg;
    logic signed [COEF_W-1:0] c_rd_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [COEF_W-1:0] op_a;
    logic signed [COEF_W-1:0] rounded;
    mac_cmd_t                 s1_reg, s2_reg, s3_reg;
    logic                     out_valid_reg;
    logic                     out_kind_reg;
    logic                     out_last_reg;
    logic [IDX_W-1:0]         out_idx_reg;
    logic signed [COEF_W-1:0] out_val_reg;

    always_ff @(posedge clk)
    begin
        if (bwe)
        begin
            basis_mem[bwaddr] <= wdata;
        end
        b_rd_reg <= basis_mem[baddr];
    end

    always_ff @(posedge clk)
    begin
        if (vwe)
        begin
            vec_mem[vwaddr] <= wdata;
        end
        v_rd_reg <= vec_mem[VA_W'(elem)];
    end

    assign rounded = round_sat(acc_reg);

    always_ff @(posedge clk)
    begin
        if (s3_reg.valid && s3_reg.last && s3_reg.kind == KIND_COEF)
        begin
            coef_mem[CA_W'(s3_reg.idx)] <= rounded;
        end
        c_rd_reg <= coef_mem[CA_W'(row)];
    end

    assign op_a = (s1_reg.kind == KIND_PROJ) ? c_rd_reg : COEF_W'(v_rd_reg);

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * b_rd_reg;
        if (s2_reg.valid)
        begin
            acc_reg <= (s2_reg.first ? ACC_W'(0) : acc_reg) + ACC_W'(prod_reg);
        end
        out_kind_reg <= s3_reg.kind;
        out_idx_reg  <= s3_reg.idx;
        out_last_reg <= s3_reg.final_out;
        out_val_reg  <= rounded;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg        <= '0;
            s2_reg        <= '0;
            s3_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_reg        <= cmd;
            s2_reg        <= s1_reg;
            s3_reg        <= s2_reg;
            out_valid_reg <= s3_reg.valid && s3_reg.last;
        end
    end

    assign result_strobe = out_valid_reg;
    assign result_kind   = out_kind_reg;
    assign result_index  = out_idx_reg;
    assign result_value  = out_val_reg;
    assign last_result   = out_valid_reg && out_last_reg;

    a_strobe_follows_step: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> $past(s3_reg.valid && s3_reg.last))
        else $error("transfer without a closing step");

    a_no_write_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_reg.valid || s2_reg.valid || s3_reg.valid) |-> !(bwe || vwe))
        else $error("store written during a run");

    a_last_marks_proj: assert property (@(posedge clk) disable iff (!rst_n)
        last_result |-> (result_strobe && result_kind == KIND_PROJ))
        else $error("last mark on a coefficient");

endmodule
`default_nettype wire

[sv/subspace_projection.sv]
// channel   | transfer when           | signals
// ----------+-------------------------+---------------------------------------------
// item in   | start && !busy at edge  | opcode, basis_row, element_index, element_value
// config    | wr_en at edge           | wr_index, wr_data
// result    | result_strobe, 1 cycle  | result_kind, result_index, result_value, last_result
//
// Basis and vector element writes go straight into their stores; busy stays low.
// A vector element that closes the vector starts a run on one shared multiply-accumulate
// unit: busy stays high through pass 1 (nb basis rows, d elements in use), a drain, pass 2
// and a second drain. A coefficient leaves per basis row, then a component per element, each
// registered through s1_reg, s2_reg, s3_reg and the output register after its closing step.
// Reset clears control only; basis and vector contents are undefined until written.
// The receiver cannot stall; results are never held.
`default_nettype none
module subspace_projection
    import subproj_pkg::*;
#(
    parameter int DIM       = 32,
    parameter int NUM_BASIS = 8
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic                     opcode,
    input  wire logic [2:0]               basis_row,
    input  wire logic [IDX_W-1:0]         element_index,
    input  wire logic signed [ELEM_W-1:0] element_value,
    input  wire logic                     wr_en,
    input  wire logic                     wr_index,
    input  wire logic [DIM_W-1:0]         wr_data,
    output logic                          result_strobe,
    output logic                          result_kind,
    output logic [IDX_W-1:0]              result_index,
    output logic signed [COEF_W-1:0]      result_value,
    output logic                          last_result
);

    localparam int BA_W = (NUM_BASIS * DIM > 1) ? $clog2(NUM_BASIS * DIM) : 1;
    localparam int VA_W = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int CA_W = (NUM_BASIS > 1) ? $clog2(NUM_BASIS) : 1;
    localparam int DLIM = (DIM < 32) ? DIM : 32;

    logic [DIM_W-1:0]  dim_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              accept;
    logic              idx_ok;
    logic              bwe, vwe, run_start;
    logic [BA_W-1:0]   bwaddr;
    logic [IDX_W-1:0]  dlast;
    logic [ROW_W-1:0]  rlast;
    int                d_eff, n_eff;
    mac_cmd_t          cmd;
    logic [BA_W-1:0]   baddr;
    logic [IDX_W-1:0]  elem;
    logic [ROW_W-1:0]  row;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_reg   <= DIM_W'(32);
            count_reg <= CNT_W'(8);
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_DIM:   dim_reg   <= wr_data;
                REG_COUNT: count_reg <= wr_data[CNT_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        d_eff = int'(dim_reg);
        if (d_eff < 1)
        begin
            d_eff = 1;
        end
        if (d_eff > DLIM)
        begin
            d_eff = DLIM;
        end
        n_eff = int'(count_reg);
        if (n_eff < 1)
        begin
            n_eff = 1;
        end
        if (n_eff > NUM_BASIS)
        begin
            n_eff = NUM_BASIS;
        end
    end

    assign dlast = IDX_W'(d_eff - 1);
    assign rlast = ROW_W'(n_eff - 1);

    assign accept    = start && !busy;
    assign idx_ok    = int'(element_index) < DIM;
    assign bwe       = accept && opcode == OP_BASIS && idx_ok && int'(basis_row) < NUM_BASIS;
    assign vwe       = accept && opcode == OP_VECTOR && idx_ok;
    assign run_start = vwe && element_index == dlast;
    assign bwaddr    = BA_W'(int'(basis_row) * DIM + int'(element_index));

    subproj_ctrl #(
        .DIM       (DIM),
        .NUM_BASIS (NUM_BASIS),
        .BA_W      (BA_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .run_start (run_start),
        .dlast     (dlast),
        .rlast     (rlast),
        .busy      (busy),
        .cmd       (cmd),
        .baddr     (baddr),
        .elem      (elem),
        .row       (row)
    );

    subproj_datapath #(
        .DIM       (DIM),
        .NUM_BASIS (NUM_BASIS),
        .BA_W      (BA_W),
        .VA_W      (VA_W),
        .CA_W      (CA_W)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .bwe           (bwe),
        .bwaddr        (bwaddr),
        .vwe           (vwe),
        .vwaddr        (VA_W'(element_index)),
        .wdata         (element_value),
        .cmd           (cmd),
        .baddr         (baddr),
        .elem          (elem),
        .row           (row),
        .result_strobe (result_strobe),
        .result_kind   (result_kind),
        .result_index  (result_index),
        .result_value  (result_value),
        .last_result   (last_result)
    );

endmodule
`default_nettype wire
